// File: hdl/bce_pkg.sv
// shared types and constants for the battery charge estimator
`timescale 1ns / 1ps
package bce_pkg;

   localparam int unsigned LevelW    = 28;    // Q12.16 level
   localparam int unsigned WholeW    = 12;
   localparam int unsigned FracW     = 16;
   localparam int unsigned RateW     = 20;    // Q0.32 rates, upper bits zero
   localparam int unsigned TimeW     = 32;
   localparam int unsigned MovedW    = 16;
   localparam int unsigned PctW      = 7;
   localparam int unsigned ProdW     = TimeW + RateW;
   localparam int unsigned AccW      = ProdW + 2;
   localparam int unsigned DivBits   = 18;    // (level - floor) * 100 fits here
   localparam int unsigned DivisorW  = 11;    // full_level - floor fits here
   localparam int unsigned CntW      = 5;
   localparam int unsigned CsrIndexW = 3;
   localparam int unsigned CsrDataW  = 20;
   localparam int unsigned ReqDataW  = 56;
   localparam int unsigned RspDataW  = 40;

   localparam logic [WholeW-1:0] PctFloor   = 12'd2500;
   localparam logic [PctW-1:0]   PctMax     = 7'd100;
   localparam logic [WholeW-1:0] StartReset = 12'd3700;
   localparam logic [WholeW-1:0] FullReset  = 12'd4095;
   localparam logic [RateW-1:0]  IdleReset  = 20'd42950;
   localparam logic [RateW-1:0]  MoveReset  = 20'd85899;
   localparam logic [RateW-1:0]  FillReset  = 20'd214748;

   // configuration register indexes
   localparam logic [CsrIndexW-1:0] RegStartLevel = 3'd0;
   localparam logic [CsrIndexW-1:0] RegFullLevel  = 3'd1;
   localparam logic [CsrIndexW-1:0] RegIdleRate   = 3'd2;
   localparam logic [CsrIndexW-1:0] RegMoveRate   = 3'd3;
   localparam logic [CsrIndexW-1:0] RegFillRate   = 3'd4;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_SETUP  = 12'b0000_0000_0010,
      S_TIMES  = 12'b0000_0000_0100,
      S_MUL_A  = 12'b0000_0000_1000,
      S_MUL_B  = 12'b0000_0001_0000,
      S_SUM    = 12'b0000_0010_0000,
      S_APPLY  = 12'b0000_0100_0000,
      S_PCT    = 12'b0000_1000_0000,
      S_PMUL   = 12'b0001_0000_0000,
      S_DLOAD  = 12'b0010_0000_0000,
      S_DIV    = 12'b0100_0000_0000,
      S_FINISH = 12'b1000_0000_0000
   } state_type;

endpackage

// File: hdl/battery_charge_estimator_core.sv
// Battery charge estimator: per-item level update, percent and result register
//
// Each accepted item updates the Q12.16 level estimate from the elapsed time, the motor
// running time and the wall/charger flags, and returns one result: the level, the state of
// charge percent and the flags as used. A small sequencer drives one shared 32x20
// multiplier through the drain or charge products and the percent scaling, and an
// 18-step restoring divider produces the percent where it is not settled without a
// division. req_tready is low while an item is in work; a finished result waits in
// the output register and the next item may be taken meanwhile. Configuration
// writes are meant for idle time; writing start_level also reloads the baseline and
// the level.
`timescale 1ns / 1ps
module battery_charge_estimator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now_ms[31:0], moved_ms[47:32], charger_active[48], charge_done[49],
   // wall_power[50], zero fill
   input  logic [bce_pkg::ReqDataW-1:0]     req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // level_whole[11:0], level_fraction[27:12], percent[34:28], wall_echo[35],
   // charging_echo[36], done_echo[37], zero fill
   output logic [bce_pkg::RspDataW-1:0]     rsp_tdata,
   input  logic                             csr_wen,
   input  logic [bce_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [bce_pkg::CsrDataW-1:0]     csr_wdata
);
   import bce_pkg::*;

   state_type state_ff;

   // configuration
   logic [WholeW-1:0] start_level_ff;
   logic [WholeW-1:0] full_level_ff;
   logic [RateW-1:0]  idle_rate_ff;
   logic [RateW-1:0]  move_rate_ff;
   logic [RateW-1:0]  fill_rate_ff;

   // estimator state
   logic              prior_wall_ff;
   logic [LevelW-1:0] baseline_ff;
   logic [LevelW-1:0] level_ff;
   logic [TimeW-1:0]  discharge_start_ff;
   logic [TimeW-1:0]  charge_start_ff;
   logic [TimeW-1:0]  moving_total_ff;

   // latched item
   logic [TimeW-1:0]  now_ff;
   logic [MovedW-1:0] moved_ff;
   logic              chg_ff;
   logic              done_ff;
   logic              wall_ff;

   // shared multiplier and accumulator
   logic [TimeW-1:0]  mul_a_ff;
   logic [RateW-1:0]  mul_b_ff;
   logic [ProdW-1:0]  prod_ff;
   logic [ProdW-1:0]  prod_in;
   logic [AccW-1:0]   acc_ff;

   // divider
   logic [DivBits-1:0]  quo_ff;
   logic [DivisorW-1:0] rem_ff;
   logic [DivisorW-1:0] divisor_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [DivisorW:0]   trial;
   logic [PctW-1:0]     pct_ff;

   // output register
   logic                rsp_tvalid_ff;
   logic [RspDataW-1:0] rsp_tdata_ff;

   // step arithmetic
   logic [TimeW:0]    mt_sum;
   logic [TimeW-1:0]  mt_sat;
   logic [TimeW-1:0]  on_time;
   logic              mt_over;
   logic [TimeW-1:0]  mt_kept;
   logic [TimeW-1:0]  hold;
   logic [TimeW-1:0]  charge_time;
   logic [AccW-1:0]   base_wide;
   logic [AccW-1:0]   drain_left;
   logic [WholeW-1:0] whole;
   logic              out_free;

   assign prod_in = ProdW'(mul_a_ff) * ProdW'(mul_b_ff);

   assign mt_sum = {1'b0, moving_total_ff} + (TimeW + 1)'(moved_ff);
   assign mt_sat = mt_sum[TimeW] ? {TimeW{1'b1}} : mt_sum[TimeW-1:0];

   assign on_time     = now_ff - discharge_start_ff;
   assign mt_over     = moving_total_ff > on_time;
   assign mt_kept     = mt_over ? '0 : moving_total_ff;
   assign hold        = on_time - mt_kept;
   assign charge_time = now_ff - charge_start_ff;

   assign base_wide  = AccW'({baseline_ff, {FracW{1'b0}}});
   assign drain_left = base_wide - acc_ff;
   assign whole      = level_ff[LevelW-1:FracW];

   assign trial = {rem_ff, quo_ff[DivBits-1]};

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         rsp_tvalid_ff      <= 1'b0;
         start_level_ff     <= StartReset;
         full_level_ff      <= FullReset;
         idle_rate_ff       <= IdleReset;
         move_rate_ff       <= MoveReset;
         fill_rate_ff       <= FillReset;
         prior_wall_ff      <= 1'b0;
         baseline_ff        <= {StartReset, {FracW{1'b0}}};
         level_ff           <= {StartReset, {FracW{1'b0}}};
         discharge_start_ff <= '0;
         charge_start_ff    <= '0;
         moving_total_ff    <= '0;
         cnt_ff             <= '0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  now_ff   <= req_tdata[TimeW-1:0];
                  moved_ff <= req_tdata[TimeW+MovedW-1:TimeW];
                  chg_ff   <= req_tdata[TimeW+MovedW];
                  done_ff  <= req_tdata[TimeW+MovedW+1];
                  wall_ff  <= req_tdata[TimeW+MovedW+2];
                  // cnt_ff marks whether this item ran the divider
                  cnt_ff   <= '0;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               moving_total_ff <= mt_sat;
               if (prior_wall_ff && !wall_ff) begin
                  discharge_start_ff <= now_ff;
                  moving_total_ff    <= '0;
                  prior_wall_ff      <= 1'b0;
                  baseline_ff        <= level_ff;
               end else if (!prior_wall_ff && wall_ff) begin
                  charge_start_ff <= now_ff;
                  prior_wall_ff   <= 1'b1;
                  baseline_ff     <= level_ff;
               end
               state_ff <= S_TIMES;
            end
            S_TIMES: begin
               moving_total_ff <= mt_kept;
               mul_a_ff        <= wall_ff ? charge_time : hold;
               mul_b_ff        <= wall_ff ? fill_rate_ff : idle_rate_ff;
               state_ff        <= S_MUL_A;
            end
            S_MUL_A: begin
               prod_ff  <= prod_in;
               mul_a_ff <= moving_total_ff;
               mul_b_ff <= move_rate_ff;
               state_ff <= S_MUL_B;
            end
            S_MUL_B: begin
               // charge: baseline plus gain; battery: first drain term
               acc_ff   <= AccW'(prod_ff) + (wall_ff ? base_wide : '0);
               prod_ff  <= prod_in;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (!wall_ff) begin
                  acc_ff <= acc_ff + AccW'(prod_ff);
               end
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (wall_ff) begin
                  if (chg_ff) begin
                     level_ff <= (acc_ff[AccW-1:LevelW+FracW] != '0) ? {LevelW{1'b1}}
                                 : acc_ff[LevelW+FracW-1:FracW];
                  end
                  // done wins over the ramp
                  if (done_ff) begin
                     level_ff    <= {full_level_ff, {FracW{1'b0}}};
                     baseline_ff <= {full_level_ff, {FracW{1'b0}}};
                  end
               end else begin
                  level_ff <= (acc_ff >= base_wide) ? '0
                              : drain_left[LevelW+FracW-1:FracW];
               end
               state_ff <= S_PCT;
            end
            S_PCT: begin
               if (full_level_ff <= PctFloor) begin
                  pct_ff   <= (whole >= PctFloor) ? PctMax : '0;
                  state_ff <= S_FINISH;
               end else if (whole < PctFloor) begin
                  pct_ff   <= '0;
                  state_ff <= S_FINISH;
               end else begin
                  mul_a_ff <= TimeW'(whole - PctFloor);
                  mul_b_ff <= RateW'(PctMax);
                  state_ff <= S_PMUL;
               end
            end
            S_PMUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_DLOAD;
            end
            S_DLOAD: begin
               quo_ff     <= prod_ff[DivBits-1:0];
               rem_ff     <= '0;
               divisor_ff <= DivisorW'(full_level_ff - PctFloor);
               cnt_ff     <= '0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               // restoring division, one quotient bit per cycle
               if (trial >= {1'b0, divisor_ff}) begin
                  rem_ff <= DivisorW'(trial - {1'b0, divisor_ff});
                  quo_ff <= {quo_ff[DivBits-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[DivisorW-1:0];
                  quo_ff <= {quo_ff[DivBits-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + CntW'(1);
               if (cnt_ff == CntW'(DivBits - 1)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         if (csr_wen) begin
            case (csr_index)
               RegStartLevel: begin
                  start_level_ff <= csr_wdata[WholeW-1:0];
                  baseline_ff    <= {csr_wdata[WholeW-1:0], {FracW{1'b0}}};
                  level_ff       <= {csr_wdata[WholeW-1:0], {FracW{1'b0}}};
               end
               RegFullLevel: full_level_ff <= csr_wdata[WholeW-1:0];
               RegIdleRate:  idle_rate_ff  <= csr_wdata[RateW-1:0];
               RegMoveRate:  move_rate_ff  <= csr_wdata[RateW-1:0];
               RegFillRate:  fill_rate_ff  <= csr_wdata[RateW-1:0];
               default: ;
            endcase
         end
      end
   end

   // result payload; percent clamps the quotient at full scale
   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_tdata_ff <= {2'b00, done_ff, chg_ff, wall_ff,
                          (cnt_ff == CntW'(DivBits) && quo_ff > DivBits'(PctMax))
                             ? PctMax
                             : ((cnt_ff == CntW'(DivBits)) ? quo_ff[PctW-1:0] : pct_ff),
                          level_ff[FracW-1:0], whole};
      end
   end

endmodule

// File: hdl/bce_checker.sv
// port-level assertions for the battery charge estimator, bound to the top level
`timescale 1ns / 1ps
module bce_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [bce_pkg::ReqDataW-1:0]  req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [bce_pkg::RspDataW-1:0]  rsp_tdata,
   input logic                          csr_wen,
   input logic [bce_pkg::CsrIndexW-1:0] csr_index,
   input logic [bce_pkg::CsrDataW-1:0]  csr_wdata
);
   import bce_pkg::*;

   // a waiting result holds still until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   // percent never above full scale
   a_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:28] <= PctMax)
      else $error("percent out of range");

   // padding bits stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspDataW-1:38] == '0)
      else $error("result padding not zero");

   // no result straight out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind battery_charge_estimator_core bce_checker u_bce_checker (.*);

// File: tb/sv/tb.sv
// testbench for battery_charge_estimator_core: directed table, then random supply sequences
`timescale 1ns / 1ps
module tb;
   import bce_pkg::*;

   localparam int unsigned QuietLimit   = 1000;
   localparam int unsigned DrainCycles  = 40;
   localparam int unsigned PhaseItems   = 86;
   localparam int unsigned PhaseCount   = 8;
   localparam int unsigned RegCount     = 5;
   localparam logic [LevelW-1:0] LevelTop = '1;
   localparam logic [RateW-1:0]  RateTop  = '1;

   // flags in the top bits, now_ms lowest, same order as req_tdata
   typedef struct packed {
      logic              wall_power;
      logic              charge_done;
      logic              charger_active;
      logic [MovedW-1:0] moved_ms;
      logic [TimeW-1:0]  now_ms;
   } gauge_in_type;

   typedef struct packed {
      logic              done_echo;
      logic              charging_echo;
      logic              wall_echo;
      logic [PctW-1:0]   percent;
      logic [FracW-1:0]  level_fraction;
      logic [WholeW-1:0] level_whole;
   } gauge_out_type;

   typedef struct packed {
      logic [TimeW-1:0]  now_ms;
      logic [MovedW-1:0] moved_ms;
      logic              chg;
      logic              done;
      logic              wall;
      logic              typed;
      logic [WholeW-1:0] whole;
      logic [FracW-1:0]  frac;
      logic [PctW-1:0]   pct;
   } drill_row_type;

   typedef enum logic [1:0] {ON_BATTERY, ON_WALL, CHARGING, CHARGED} supply_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqDataW-1:0]  req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RspDataW-1:0]  rsp_tdata;
   logic                 csr_wen = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_wdata = '0;

   battery_charge_estimator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // estimator state and registers as the testbench sees them
   logic [WholeW-1:0] cfg_start, cfg_full;
   logic [RateW-1:0]  cfg_idle, cfg_move, cfg_fill;
   logic              est_prior_wall;
   logic [LevelW-1:0] est_baseline, est_level;
   logic [TimeW-1:0]  est_dis_start, est_chg_start, est_moving;

   gauge_out_type level_expect_q[$];
   int unsigned   error_count = 0;
   int unsigned   sender_idle_pct = 0;
   int unsigned   receiver_stall_pct = 0;
   int unsigned   quiet_cycles = 0;

   // random sequence state
   logic [TimeW-1:0] gen_now = '0;
   supply_mode_type  gen_mode = ON_BATTERY;
   int unsigned      gen_run = 0;

   // directed items: now, moved, chg, done, wall, typed, whole, frac, percent
   drill_row_type drill_table [15] = '{
      '{32'd0,          16'd0,     1'b0, 1'b0, 1'b0, 1'b1, 12'd3700, 16'd0,     7'd75},
      '{32'd1000,       16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 12'd0,    16'd0,     7'd0},
      '{32'd2000,       16'd500,   1'b0, 1'b0, 1'b0, 1'b0, 12'd0,    16'd0,     7'd0},
      // motion longer than the time on battery is dropped
      '{32'd2100,       16'hFFFF,  1'b0, 1'b0, 1'b0, 1'b0, 12'd0,    16'd0,     7'd0},
      // wall arrives, level held while neither charging nor done
      '{32'd3000,       16'd0,     1'b0, 1'b0, 1'b1, 1'b0, 12'd0,    16'd0,     7'd0},
      '{32'd3500,       16'd0,     1'b0, 1'b0, 1'b1, 1'b0, 12'd0,    16'd0,     7'd0},
      '{32'd10000,      16'd0,     1'b1, 1'b0, 1'b1, 1'b0, 12'd0,    16'd0,     7'd0},
      // done wins over the charge ramp
      '{32'd20000,      16'd0,     1'b1, 1'b1, 1'b1, 1'b1, 12'd4095, 16'd0,     7'd100},
      '{32'd30000,      16'd0,     1'b0, 1'b0, 1'b0, 1'b1, 12'd4095, 16'd0,     7'd100},
      // time on battery wraps to the top, drain exceeds the baseline
      '{32'd29999,      16'd0,     1'b0, 1'b0, 1'b0, 1'b1, 12'd0,    16'd0,     7'd0},
      '{32'hFFFF_FFFF,  16'd0,     1'b1, 1'b0, 1'b1, 1'b1, 12'd0,    16'd0,     7'd0},
      // longest charge time saturates the level
      '{32'hFFFF_FFFE,  16'd0,     1'b1, 1'b0, 1'b1, 1'b1, 12'd4095, 16'hFFFF,  7'd100},
      '{32'd5,          16'd0,     1'b0, 1'b1, 1'b1, 1'b1, 12'd4095, 16'd0,     7'd100},
      // charger flags on battery are only echoed
      '{32'd100,        16'd0,     1'b1, 1'b1, 1'b0, 1'b1, 12'd4095, 16'd0,     7'd100},
      '{32'd70000,      16'hFFFF,  1'b0, 1'b0, 1'b0, 1'b0, 12'd0,    16'd0,     7'd0}
   };

   function automatic void restore_model();
      cfg_start      = StartReset;
      cfg_full       = FullReset;
      cfg_idle       = IdleReset;
      cfg_move       = MoveReset;
      cfg_fill       = FillReset;
      est_prior_wall = 1'b0;
      est_baseline   = {StartReset, 16'h0000};
      est_level      = {StartReset, 16'h0000};
      est_dis_start  = '0;
      est_chg_start  = '0;
      est_moving     = '0;
   endfunction

   function automatic gauge_out_type estimate_level(input gauge_in_type it);
      logic [TimeW-1:0] on_time, hold, chg_time;
      logic [63:0]      acc, drain;
      int unsigned      whole32, span, q;
      gauge_out_type    r;
      if (est_moving > TimeW'(32'hFFFF_FFFF) - TimeW'(it.moved_ms))
         est_moving = '1;
      else
         est_moving = est_moving + TimeW'(it.moved_ms);
      if (est_prior_wall && !it.wall_power) begin
         est_dis_start  = it.now_ms;
         est_moving     = '0;
         est_prior_wall = 1'b0;
         est_baseline   = est_level;
      end else if (!est_prior_wall && it.wall_power) begin
         est_chg_start  = it.now_ms;
         est_prior_wall = 1'b1;
         est_baseline   = est_level;
      end
      on_time = it.now_ms - est_dis_start;
      if (est_moving > on_time)
         est_moving = '0;
      hold     = on_time - est_moving;
      chg_time = it.now_ms - est_chg_start;
      if (it.wall_power) begin
         if (it.charger_active) begin
            acc = (64'(est_baseline) << 16) + 64'(chg_time) * 64'(cfg_fill);
            acc = acc >> 16;
            est_level = (acc > 64'(LevelTop)) ? LevelTop : acc[LevelW-1:0];
         end
         if (it.charge_done) begin
            est_level    = {cfg_full, 16'h0000};
            est_baseline = est_level;
         end
      end else begin
         acc   = 64'(est_baseline) << 16;
         drain = 64'(hold) * 64'(cfg_idle) + 64'(est_moving) * 64'(cfg_move);
         acc   = acc - drain;
         est_level = (drain >= (64'(est_baseline) << 16)) ? '0 : acc[LevelW+15:16];
      end
      whole32 = 32'(est_level[LevelW-1:FracW]);
      span    = 32'(cfg_full);
      if (span <= PctFloor)
         r.percent = (whole32 >= PctFloor) ? PctMax : '0;
      else if (whole32 < PctFloor)
         r.percent = '0;
      else begin
         q = (whole32 - PctFloor) * 32'(PctMax) / (span - PctFloor);
         r.percent = (q > PctMax) ? PctMax : q[PctW-1:0];
      end
      r.level_whole    = est_level[LevelW-1:FracW];
      r.level_fraction = est_level[FracW-1:0];
      r.wall_echo      = it.wall_power;
      r.charging_echo  = it.charger_active;
      r.done_echo      = it.charge_done;
      return r;
   endfunction

   // mostly well-formed supply runs with rising time, some plain noise
   function automatic gauge_in_type draw_item();
      gauge_in_type it;
      int unsigned  pick, delta, cap;
      if ($urandom_range(99) < 10) begin
         it = gauge_in_type'($bits(gauge_in_type)'({$urandom, $urandom}));
         return it;
      end
      if (gen_run == 0) begin
         gen_mode = supply_mode_type'($urandom_range(3));
         gen_run  = $urandom_range(12, 1);
      end
      gen_run--;
      pick = $urandom_range(99);
      if (pick < 50)
         delta = $urandom_range(2000);
      else if (pick < 80)
         delta = $urandom_range(1 << 20);
      else if (pick < 97)
         delta = $urandom_range(1 << 26);
      else
         delta = $urandom;
      gen_now   = gen_now + delta;
      it.now_ms = gen_now;
      cap = (delta > 65535) ? 65535 : delta;
      it.moved_ms = ($urandom_range(3) == 0) ? MovedW'($urandom) : MovedW'($urandom_range(cap));
      case (gen_mode)
         ON_BATTERY: begin
            it.wall_power     = 1'b0;
            it.charger_active = ($urandom_range(9) == 0);
            it.charge_done    = ($urandom_range(9) == 0);
         end
         ON_WALL: begin
            it.wall_power     = 1'b1;
            it.charger_active = 1'b0;
            it.charge_done    = 1'b0;
         end
         CHARGING: begin
            it.wall_power     = 1'b1;
            it.charger_active = 1'b1;
            it.charge_done    = (gen_run == 0) && ($urandom_range(1) == 1);
         end
         default: begin
            it.wall_power     = 1'b1;
            it.charger_active = ($urandom_range(1) == 1);
            it.charge_done    = 1'b1;
         end
      endcase
      return it;
   endfunction

   task automatic send_item(input gauge_in_type it, input bit typed, input gauge_out_type want);
      gauge_out_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataW'(it);
      do @(posedge clock); while (!req_tready);
      predicted = estimate_level(it);
      level_expect_q.push_back(typed ? want : predicted);
   endtask

   // leaves csr_wen high, the caller lowers it after the last write
   task automatic write_reg(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         RegStartLevel: begin
            cfg_start    = data[WholeW-1:0];
            est_baseline = {cfg_start, 16'h0000};
            est_level    = est_baseline;
         end
         RegFullLevel: cfg_full = data[WholeW-1:0];
         RegIdleRate:  cfg_idle = data[RateW-1:0];
         RegMoveRate:  cfg_move = data[RateW-1:0];
         RegFillRate:  cfg_fill = data[RateW-1:0];
         default: ;
      endcase
   endtask

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_side
      gauge_out_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(gauge_out_type)-1:0];
            if (level_expect_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               error_count++;
            end else begin
               want = level_expect_q.pop_front();
               check_field("level_whole", want.level_whole, got.level_whole);
               check_field("level_fraction", want.level_fraction, got.level_fraction);
               check_field("percent", want.percent, got.percent);
               check_field("wall_echo", want.wall_echo, got.wall_echo);
               check_field("charging_echo", want.charging_echo, got.charging_echo);
               check_field("done_echo", want.done_echo, got.done_echo);
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      gauge_in_type  it;
      gauge_out_type want;
      restore_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_table[i]) begin
         it   = '{wall_power: drill_table[i].wall, charge_done: drill_table[i].done,
                  charger_active: drill_table[i].chg, moved_ms: drill_table[i].moved_ms,
                  now_ms: drill_table[i].now_ms};
         want = '{done_echo: drill_table[i].done, charging_echo: drill_table[i].chg,
                  wall_echo: drill_table[i].wall, percent: drill_table[i].pct,
                  level_fraction: drill_table[i].frac, level_whole: drill_table[i].whole};
         send_item(it, drill_table[i].typed, want);
      end
      req_tvalid <= 1'b0;

      for (int p = 1; p <= PhaseCount; p++) begin
         // registers change only with nothing in flight
         while (level_expect_q.size() != 0) @(posedge clock);
         case (p)
            1: begin
               write_reg(RegStartLevel, RateTop);
               write_reg(RegFullLevel, CsrDataW'(PctFloor) + 1);
               write_reg(RegIdleRate, RateTop);
               write_reg(RegMoveRate, RateTop);
               write_reg(RegFillRate, RateTop);
            end
            2: begin
               write_reg(RegStartLevel, '0);
               write_reg(RegFullLevel, CsrDataW'(FullReset));
               write_reg(RegIdleRate, '0);
               write_reg(RegMoveRate, '0);
               write_reg(RegFillRate, '0);
            end
            3: begin
               write_reg(RegStartLevel, CsrDataW'(PctFloor));
               write_reg(RegFullLevel, CsrDataW'(PctFloor));
               write_reg(RegIdleRate, CsrDataW'($urandom));
               write_reg(RegMoveRate, CsrDataW'($urandom));
               write_reg(RegFillRate, CsrDataW'($urandom));
            end
            4: begin
               write_reg(RegStartLevel, CsrDataW'($urandom));
               write_reg(RegFullLevel, '0);
               write_reg(RegIdleRate, CsrDataW'($urandom));
               write_reg(RegMoveRate, CsrDataW'($urandom));
               write_reg(RegFillRate, CsrDataW'($urandom));
               write_reg(CsrIndexW'($urandom_range(2 ** CsrIndexW - 1, RegCount)),
                         CsrDataW'($urandom));
            end
            default: begin
               write_reg(RegStartLevel, CsrDataW'($urandom));
               write_reg(RegFullLevel, ($urandom_range(1) == 1) ? CsrDataW'($urandom)
                        : CsrDataW'($urandom_range(FullReset, PctFloor + 1)));
               write_reg(RegIdleRate, CsrDataW'($urandom));
               write_reg(RegMoveRate, CsrDataW'($urandom));
               write_reg(RegFillRate, CsrDataW'($urandom));
               if (p == 6)
                  write_reg(CsrIndexW'($urandom_range(2 ** CsrIndexW - 1, RegCount)),
                            CsrDataW'($urandom));
            end
         endcase
         csr_wen <= 1'b0;

         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
            default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
         endcase

         for (int n = 0; n < PhaseItems; n++)
            send_item(draw_item(), 1'b0, '0);
         req_tvalid <= 1'b0;
      end

      while (level_expect_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
